FILE: design/score_history_window_stats_unit_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef SCORE_HISTORY_WINDOW_STATS_UNIT_ASSERT_SVH
`define SCORE_HISTORY_WINDOW_STATS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SHW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/shwsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shwsu_pkg;

  localparam int unsigned SCORE_W     = 32;
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned FILL_OUT_W  = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 104;

  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: design/shwsu_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module shwsu_ring #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = 3,
  parameter int unsigned DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/shwsu_div.sv
`timescale 1ns / 1ps
`default_nettype none

module shwsu_div #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [DEN_W-1:0] den_i,
  output shwsu_pkg::div_stat_t         stat_o,
  output logic signed      [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_q, q_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_sh = {rem_q, q_q[NUM_W-1]};
    trial  = rem_sh - {1'b0, den_q};
    q_d    = q_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (!trial[DEN_W]) begin
        rem_d = trial[DEN_W-1:0];
        q_d   = {q_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        q_d   = {q_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i[NUM_W-1] ? (~num_i + NUM_W'(1)) : num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NUM_W-1];
    end else begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o      = neg_q ? $signed(~q_q + NUM_W'(1)) : $signed(q_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

FILE: design/score_history_window_stats_unit.sv
// Channel   Dir  tdata fields (low bit up)                               Handshake
// s_axis    in   opcode[1:0] score[33:2] zero[39:34]                      tvalid/tready
// m_axis    out  max[31:0] min[63:32] mean[95:64] fill[99:96] zero[103:100] tvalid/tready
//
// One transaction in walks each stored entry through S_RD, the ring read, and S_ACC, the
// shared compare/add, then runs the serial divider at one bit a cycle (SUM_W = 36 at
// depth 8).
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; a stalled m_axis holds it and blocks the next finish.
// rst_ni clears pointer, fill level and all valid flags; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "score_history_window_stats_unit_assert.svh"

module score_history_window_stats_unit #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // opcode[1:0], score[33:2]
  input  wire logic [shwsu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // max_score[31:0], min_score[63:32], mean_score[95:64], fill_count[99:96]
  output logic [shwsu_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  localparam int unsigned PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W  = shwsu_pkg::SCORE_W + FILL_W;
  localparam int unsigned SW     = shwsu_pkg::SCORE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [PTR_W-1:0]             wptr_q, wptr_d;
  logic [FILL_W-1:0]            fill_q, fill_d;
  logic [PTR_W-1:0]             idx_q;
  logic signed [SW-1:0]         max_q, min_q, mean_q;
  logic signed [SUM_W-1:0]      sum_q;
  logic                         out_valid_q;
  logic [shwsu_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic [shwsu_pkg::OPCODE_W-1:0] opcode;
  logic [SW-1:0]                score;
  logic                         in_fire;
  logic                         push;
  logic                         out_load;
  logic                         last_entry;
  logic [SW-1:0]                rdata;
  logic signed [SW-1:0]         rval;
  logic                         div_start;
  shwsu_pkg::div_stat_t         div_stat;
  logic signed [SUM_W-1:0]      div_quot;
  logic [FILL_W+3:0]            fill_ext;

  assign opcode     = s_axis_tdata[shwsu_pkg::OPCODE_W-1:0];
  assign score      = s_axis_tdata[shwsu_pkg::OPCODE_W +: SW];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign push       = in_fire && (opcode == shwsu_pkg::OP_PUSH);
  assign rval       = $signed(rdata);
  assign last_entry = ({{(FILL_W){1'b0}}, idx_q} == ((PTR_W + FILL_W)'(fill_q) - (PTR_W + FILL_W)'(1)));
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  assign div_start  = (state_q == S_DIVS);
  assign fill_ext   = {4'b0, fill_q};

  shwsu_ring #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (PTR_W),
    .DATA_W (SW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wptr_q),
    .wdata_i (score),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  shwsu_div #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (fill_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  always_comb begin
    wptr_d = wptr_q;
    fill_d = fill_q;
    case (opcode)
      shwsu_pkg::OP_PUSH: begin
        wptr_d = (wptr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
        if (fill_q != FILL_W'(HISTORY_DEPTH)) begin
          fill_d = fill_q + FILL_W'(1);
        end
      end
      shwsu_pkg::OP_CLEAR: begin
        wptr_d = '0;
        fill_d = '0;
      end
      default: begin
        wptr_d = wptr_q;
        fill_d = fill_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = (fill_d == '0) ? S_OUT : S_RD;
      S_RD:   state_d = S_ACC;
      S_ACC:  state_d = last_entry ? S_DIVS : S_RD;
      S_DIVS: state_d = S_DIVW;
      S_DIVW: if (div_stat.done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wptr_q      <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        wptr_q <= wptr_d;
        fill_q <= fill_d;
        idx_q  <= '0;
      end else if (state_q == S_ACC) begin
        idx_q <= idx_q + PTR_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      max_q  <= '0;
      min_q  <= '0;
      sum_q  <= '0;
      mean_q <= '0;
    end else if (state_q == S_ACC) begin
      if (idx_q == '0) begin
        max_q <= rval;
        min_q <= rval;
        sum_q <= SUM_W'(rval);
      end else begin
        if (rval > max_q) max_q <= rval;
        if (rval < min_q) min_q <= rval;
        sum_q <= sum_q + SUM_W'(rval);
      end
    end else if ((state_q == S_DIVW) && div_stat.done) begin
      mean_q <= div_quot[SW-1:0];
    end
    if (out_load) begin
      out_data_q <= {4'b0, fill_ext[3:0], mean_q, min_q, max_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `SHW_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1,
    fill_q <= FILL_W'(HISTORY_DEPTH), "fill level above depth")
  `SHW_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni,
    in_fire && (opcode == shwsu_pkg::OP_CLEAR), (fill_q == '0) && (wptr_q == '0),
    "clear did not empty history")
  `SHW_ASSERT_NOW(a_div_start_idle, clk_i, rst_ni, div_start, !div_stat.busy,
    "divider started while busy")
  `SHW_ASSERT_NOW(a_walk_nonempty, clk_i, rst_ni, (state_q == S_RD) || (state_q == S_ACC),
    fill_q != '0, "walk over empty history")

endmodule

`default_nettype wire
